// ----- sv/sha256_pkg.sv -----
// Package for the SHA-256 message hash block: types, constants, round functions.
// No dependencies.
package sha256_pkg;

    localparam int unsigned DigestWidth = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        load_byte;
        logic [7:0]  byte_val;
        logic        count_bits;
        logic        clear_count;
        logic        start_comp;
        logic        reset_hash;
        logic        len_byte;
        logic [2:0]  len_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic        comp_busy;
        logic [5:0]  byte_pos;
    } t_dp_sts;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage

// ----- sv/sha256_message_hash_top.sv -----
// Top level of the SHA-256 message hash: stream ports, controller and datapath.
// Depends on sha256_pkg, sha256_ctrl, sha256_datapath.
// The 64th byte of a block starts the 64-round compression (one round per cycle
// in the shared round unit).
// Finish: padding bytes one per cycle (paused by a compression), 8 length bytes, one
// or two compressions, then four digest words, one per cycle while the sink is ready.
// Reset (synchronous, active low) restores the initial hash, zero count and idle state.
module sha256_message_hash_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] message_byte
    input  logic                               s_axis_tuser,   // [0] action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sha256_pkg::DigestWidth-1:0] m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]                         m_axis_tuser,   // [1:0] word_index
    output logic                               m_axis_tlast
);
    import sha256_pkg::*;

    t_dp_cmd      cmd;
    t_dp_sts      sts;
    logic [255:0] hash;
    logic [1:0]   idx;

    sha256_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .o_cmd    (cmd),
        .i_sts    (sts),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_idx    (idx)
    );

    sha256_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_hash  (hash)
    );

    assign m_axis_tdata = hash[(2'd3 - idx) * 64 +: 64];
    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 2'd3);
endmodule

// ----- sv/sha256_datapath.sv -----
// Datapath: byte packing, block buffer, 16-word rolling schedule, round unit, hash.
// Depends on sha256_pkg.
module sha256_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_dp_cmd   i_cmd,
    output sha256_pkg::t_dp_sts   o_sts,
    output logic [255:0]          o_hash
);
    import sha256_pkg::*;

    logic [31:0] r_buf [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_v   [8];
    logic [31:0] r_h   [8];
    logic [5:0]  r_pos;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_fin;

    logic [7:0]  byte_in;
    logic [31:0] w_new, w_cur, t1, t2;
    logic        put;

    always_comb begin
        byte_in = i_cmd.len_byte ? r_len[{i_cmd.len_idx, 3'b000} +: 8] : i_cmd.byte_val;
        put     = i_cmd.load_byte || i_cmd.len_byte;
        w_cur   = r_w[0];
        w_new   = sig1(r_w[14]) + r_w[9] + sig0(r_w[1]) + r_w[0];
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + RoundK[r_rnd] + w_cur;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (put) begin
            if (r_pos[1:0] == 2'd0) begin
                r_buf[r_pos[5:2]] <= {byte_in, 24'd0};
            end else begin
                r_buf[r_pos[5:2]][(5'd3 - {3'd0, r_pos[1:0]}) * 8 +: 8] <= byte_in;
            end
        end
        if (i_cmd.clear_count) begin
            r_len <= r_bits;
        end
        if (i_cmd.start_comp) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
            for (int i = 0; i < 8; i++)  r_v[i] <= r_h[i];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_new;
            for (int i = 1; i < 8; i++) r_v[i] <= r_v[i - 1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_bits <= '0;
            r_rnd  <= '0;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= StartHash[i];
        end else begin
            if (put) r_pos <= r_pos + 6'd1;
            if (i_cmd.clear_count) begin
                r_bits <= '0;
            end else if (i_cmd.count_bits) begin
                r_bits <= r_bits + 64'd8;
            end
            r_fin <= 1'b0;
            if (i_cmd.start_comp) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end else if (i_cmd.reset_hash) begin
                for (int i = 0; i < 8; i++) r_h[i] <= StartHash[i];
            end
        end
    end

    always_comb begin
        o_sts.comp_busy  = r_busy || r_fin;
        o_sts.byte_pos   = r_pos;
        for (int i = 0; i < 8; i++) o_hash[(7 - i) * 32 +: 32] = r_h[i];
    end
endmodule

// ----- sv/sha256_ctrl.sv -----
// Controller: sequences byte intake, padding, length bytes, compression and digest output.
// Depends on sha256_pkg.
module sha256_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [7:0]            i_byte,
    output sha256_pkg::t_dp_cmd   o_cmd,
    input  sha256_pkg::t_dp_sts   i_sts,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_idx
);
    import sha256_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_idx, n_idx;
    logic       r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_pend  = 1'b0;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!i_action) begin
                        o_cmd.load_byte  = 1'b1;
                        o_cmd.byte_val   = i_byte;
                        o_cmd.count_bits = 1'b1;
                        n_pend = i_sts.byte_pos == 6'd63;
                        if (n_pend) begin
                            n_state = ST_COMP;
                            n_ret   = ST_IDLE;
                        end
                    end else begin
                        o_cmd.load_byte   = 1'b1;
                        o_cmd.byte_val    = PadByte;
                        o_cmd.clear_count = 1'b1;
                        n_pend  = i_sts.byte_pos == 6'd63;
                        n_state = ST_COMP;
                        n_ret   = ST_PAD;
                        if (!n_pend) n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (i_sts.byte_pos == LenPos) begin
                    n_state = ST_LEN;
                    n_cnt   = 3'd7;
                end else begin
                    o_cmd.load_byte = 1'b1;
                    n_pend = i_sts.byte_pos == 6'd63;
                    if (n_pend) begin
                        n_state = ST_COMP;
                        n_ret   = ST_PAD;
                    end
                end
            end
            ST_LEN: begin
                o_cmd.len_byte = 1'b1;
                o_cmd.len_idx  = r_cnt;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_pend  = 1'b1;
                    n_state = ST_COMP;
                    n_ret   = ST_EMIT;
                    n_idx   = '0;
                end
            end
            ST_COMP: begin
                if (r_pend) begin
                    o_cmd.start_comp = 1'b1;
                end else if (!i_sts.comp_busy) begin
                    n_state = r_ret;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        o_cmd.reset_hash = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- sv/sha256_checker.sv -----
// Port-level checker for the SHA-256 hash top level, bound to it.
// Depends on sha256_message_hash_top.
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("tlast mismatch");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while emitting");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("digest word order");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("stalled word changed");
endmodule

bind sha256_message_hash_top sha256_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- test/tb.sv -----
// Testbench for sha256_message_hash_top: streams messages and checks digest words.
// Depends on sha256_pkg and the block's RTL; predicts digests with a local SHA-256 model.
`timescale 1ns / 100ps

class digest_board;
    logic [63:0] exp_word [$];
    logic [1:0]  exp_idx [$];
    logic        exp_last [$];
    logic [31:0] hval [8];
    logic [31:0] blk [16];
    logic [5:0]  pos;
    logic [63:0] nbits;
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) hval[i] = sha256_pkg::StartHash[i];
        pos = '0;
        nbits = '0;
    endfunction

    function logic [31:0] rr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 64; t++)
            w[t] = (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int t = 0; t < 8; t++) v[t] = hval[t];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[t] + w[t];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) hval[t] += v[t];
    endfunction

    function void push_byte(logic [7:0] b);
        if (pos[1:0] == 0) blk[pos[5:2]] = {b, 24'h0};
        else blk[pos[5:2]] |= 32'(b) << (8 * (3 - pos[1:0]));
        pos++;
        if (pos == 0) compress();
    endfunction

    function void note_word(logic action, logic [7:0] data);
        logic [63:0] len;
        if (!action) begin
            push_byte(data);
            nbits += 64'd8;
            return;
        end
        len = nbits;
        push_byte(8'h80);
        while (pos != 56) push_byte(8'h00);
        for (int i = 7; i >= 0; i--) push_byte(len[i*8 +: 8]);
        for (int i = 0; i < 4; i++) begin
            exp_word.insert(exp_word.size(), {hval[2*i], hval[2*i+1]});
            exp_idx.insert(exp_idx.size(), 2'(i));
            exp_last.insert(exp_last.size(), i == 3);
        end
        restart();
    endfunction

    function void report(string msg);
        $display("ERROR %0t: %s", $time, msg);
        errors++;
    endfunction

    function void check_word(logic [63:0] d, logic [1:0] idx, logic lst);
        logic [63:0] ew;
        logic [1:0]  ei;
        logic        el;
        if (exp_word.size() == 0) begin
            report($sformatf("unexpected word %h", d));
            return;
        end
        ew = exp_word.pop_front();
        ei = exp_idx.pop_front();
        el = exp_last.pop_front();
        if (d !== ew) report($sformatf("digest %h, expected %h", d, ew));
        if (idx !== ei) report($sformatf("index %0d, expected %0d", idx, ei));
        if (lst !== el) report($sformatf("last %b, expected %b", lst, el));
    endfunction
endclass

module tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    digest_board board = new();
    int src_idle = 0;
    int snk_stall = 0;

    sha256_message_hash_top uut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic send(logic action, logic [7:0] data);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= action;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_word(action, data);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.exp_word.size() != 0) @(posedge i_clk);
    endtask

    task automatic message(int len);
        for (int i = 0; i < len; i++) send(1'b0, 8'($urandom));
        send(1'b1, 8'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // empty message, then a length whose padding spills into a second block
        send(1'b1, 8'hff);
        message(56);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            src_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 62 : 28) : 0;
            snk_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 62 : 28) : 0;
            for (int m = 0; m < 3; m++)
                message($urandom_range(8));
            drain();
        end
        src_idle = 0;
        snk_stall = 0;
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.exp_word.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
